>>> design/rieu_pkg.sv
`default_nettype none
package rieu_pkg;

	localparam logic [31:0] STACK_TOP = 32'd4000;
	localparam logic [31:0] HALT_WORD = 32'hffffffff;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_SUB  = 5'd1,
		OP_MUL  = 5'd2,
		OP_DIV  = 5'd3,
		OP_MOD  = 5'd4,
		OP_CMP  = 5'd5,
		OP_AND  = 5'd6,
		OP_OR   = 5'd7,
		OP_NOT  = 5'd8,
		OP_MOV  = 5'd9,
		OP_LSL  = 5'd10,
		OP_LSR  = 5'd11,
		OP_ASR  = 5'd12,
		OP_NOP  = 5'd13,
		OP_LD   = 5'd14,
		OP_ST   = 5'd15,
		OP_BEQ  = 5'd16,
		OP_BGT  = 5'd17,
		OP_B    = 5'd18,
		OP_CALL = 5'd19,
		OP_RET  = 5'd20
	} opcode_t;

	localparam logic CMD_EXEC = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] instruction;
		logic [31:0] load_data;
	} in_item_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        branch_taken;
		logic        mem_read;
		logic        mem_write;
		logic [31:0] mem_address;
		logic [31:0] store_data;
		logic        reg_write;
		logic [3:0]  reg_index;
		logic [31:0] reg_value;
		logic        halted;
		logic        div_zero;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DIVFIN,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic execute;
		logic div_step;
		logic div_finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} dp_status_t;

endpackage
`default_nettype wire

>>> design/risc_instruction_execute_unit.sv
// An accepted item is captured, executed, then held as the result; div and mod
// with a nonzero divisor add 32 steps of the restoring divider plus one to finish.
// Throughput: one item at a time; next accepted the cycle after its result is taken.
// Reset: asynchronous, clears PC, flags, pending load and halt; r14 = STACK_TOP.
`default_nettype none
module risc_instruction_execute_unit (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  rieu_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output rieu_pkg::out_item_t  out_data
);
	import rieu_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	rieu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
	);

	rieu_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cmd(cmd),
		.status(status), .out_item(out_data)
	);
endmodule
`default_nettype wire

>>> design/rieu_ctrl.sv
`default_nettype none
module rieu_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire                     out_ready,
	input  rieu_pkg::dp_status_t    status,
	output rieu_pkg::ctrl_cmd_t     cmd
);
	import rieu_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_EXEC;
			ST_EXEC:   state_d = status.need_div ? ST_DIV : ST_OUT;
			ST_DIV:    if (status.div_last) state_d = ST_DIVFIN;
			ST_DIVFIN: state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC:   cmd.execute = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_DIVFIN: cmd.div_finish = 1'b1;
			ST_OUT:    out_valid = 1'b1;
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_div_only_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_DIV))
		else $error("divide state entered out of order");
	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result held");
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("more than one command");
endmodule
`default_nettype wire

>>> design/rieu_datapath.sv
`default_nettype none
module rieu_datapath (
	input  wire                     clk,
	input  wire                     arst_n,
	input  rieu_pkg::in_item_t      in_item,
	input  rieu_pkg::ctrl_cmd_t     cmd,
	output rieu_pkg::dp_status_t    status,
	output rieu_pkg::out_item_t     out_item
);
	import rieu_pkg::*;

	logic [31:0] regs_q [16];
	logic [31:0] pc_q;
	logic        gt_q, eq_q, ldp_q, halt_q;
	logic [3:0]  ldd_q;
	in_item_t    item_q;
	out_item_t   res_q;

	// divider: restoring, one bit per cycle
	logic [31:0] dq_q, drem_q, dden_q, dsor_q;
	logic [4:0]  dcnt_q;
	logic        dop_mod_q, dneg_q_q, dneg_r_q;
	logic [3:0]  drd_q;

	logic [31:0] w, a, b, immv, off, target, pc4, res, ma, mb;
	logic [4:0]  op, sh;
	logic [3:0]  rd;
	logic        wb, na, nb;
	logic [32:0] trial;
	logic [31:0] rem_sh, qfin, rfin;

	assign w   = item_q.instruction;
	assign op  = w[31:27];
	assign rd  = w[25:22];
	assign a   = regs_q[w[21:18]];
	assign pc4 = pc_q + 32'd4;

	always_comb begin
		case (w[17:16])
			2'd0:    immv = {{16{w[15]}}, w[15:0]};
			2'd2:    immv = {w[15:0], 16'h0000};
			default: immv = {16'h0000, w[15:0]};
		endcase
	end

	assign b      = w[26] ? immv : regs_q[w[17:14]];
	assign off    = {{5{w[26]}}, w[26:0]};
	assign target = pc_q + {off[29:0], 2'b00};
	assign sh     = b[4:0];
	assign na     = a[31];
	assign nb     = b[31];
	assign ma     = na ? 32'd0 - a : a;
	assign mb     = nb ? 32'd0 - b : b;

	always_comb begin
		res = '0;
		wb  = 1'b1;
		case (op)
			OP_ADD: res = a + b;
			OP_SUB: res = a - b;
			OP_MUL: res = a * b;
			OP_AND: res = a & b;
			OP_OR:  res = a | b;
			OP_NOT: res = ~b;
			OP_MOV: res = b;
			OP_LSL: res = a << sh;
			OP_LSR: res = a >> sh;
			OP_ASR: res = $signed(a) >>> sh;
			OP_CALL: res = pc4;
			default: wb = 1'b0;
		endcase
	end

	assign status.need_div = cmd.execute && !halt_q && item_q.command == CMD_EXEC && !ldp_q
		&& w != HALT_WORD && (op == OP_DIV || op == OP_MOD) && mb != 32'd0;
	assign status.div_last = dcnt_q == 5'd0;

	assign rem_sh = {drem_q[30:0], dden_q[31]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dsor_q};
	assign qfin = dneg_q_q ? 32'd0 - dq_q : dq_q;
	assign rfin = dneg_r_q ? 32'd0 - drem_q : drem_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_item;
		if (cmd.execute) begin
			dq_q      <= '0;
			drem_q    <= '0;
			dden_q    <= ma;
			dsor_q    <= mb;
			dcnt_q    <= 5'd31;
			dop_mod_q <= op == OP_MOD;
			dneg_q_q  <= na ^ nb;
			dneg_r_q  <= na;
			drd_q     <= rd;
		end
		if (cmd.div_step) begin
			dden_q <= {dden_q[30:0], 1'b0};
			dcnt_q <= dcnt_q - 5'd1;
			if (!trial[32]) begin
				drem_q <= trial[31:0];
				dq_q   <= {dq_q[30:0], 1'b1};
			end else begin
				drem_q <= rem_sh;
				dq_q   <= {dq_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) regs_q[i] <= '0;
			regs_q[14] <= STACK_TOP;
			pc_q   <= '0;
			gt_q   <= 1'b0;
			eq_q   <= 1'b0;
			ldp_q  <= 1'b0;
			ldd_q  <= '0;
			halt_q <= 1'b0;
			res_q  <= '0;
		end else if (cmd.div_finish) begin
			res_q.reg_write <= 1'b1;
			res_q.reg_index <= drd_q;
			res_q.reg_value <= dop_mod_q ? rfin : qfin;
			regs_q[drd_q]   <= dop_mod_q ? rfin : qfin;
		end else if (cmd.execute) begin
			res_q <= '0;
			res_q.next_pc <= pc_q;
			res_q.halted  <= halt_q;
			if (halt_q) begin
			end else if (item_q.command == CMD_LOAD) begin
				if (ldp_q) begin
					regs_q[ldd_q]   <= item_q.load_data;
					res_q.reg_write <= 1'b1;
					res_q.reg_index <= ldd_q;
					res_q.reg_value <= item_q.load_data;
					ldp_q <= 1'b0;
				end
			end else if (ldp_q) begin
			end else if (w == HALT_WORD) begin
				halt_q <= 1'b1;
				res_q.halted <= 1'b1;
			end else begin
				pc_q <= pc4;
				res_q.next_pc <= pc4;
				if (wb) begin
					regs_q[op == OP_CALL ? 4'd15 : rd] <= res;
					res_q.reg_write <= 1'b1;
					res_q.reg_index <= op == OP_CALL ? 4'd15 : rd;
					res_q.reg_value <= res;
				end
				case (op)
					OP_DIV, OP_MOD: if (mb == 32'd0) begin
						res_q.div_zero  <= 1'b1;
						res_q.reg_write <= 1'b1;
						res_q.reg_index <= rd;
						res_q.reg_value <= '0;
						regs_q[rd]      <= '0;
					end
					OP_CMP: begin
						gt_q <= $signed(a) > $signed(b);
						eq_q <= a == b;
					end
					OP_LD: begin
						res_q.mem_read    <= 1'b1;
						res_q.mem_address <= a + b;
						ldp_q <= 1'b1;
						ldd_q <= rd;
					end
					OP_ST: begin
						res_q.mem_write   <= 1'b1;
						res_q.mem_address <= a + b;
						res_q.store_data  <= regs_q[rd];
					end
					OP_BEQ: if (eq_q) begin
						pc_q <= target; res_q.next_pc <= target; res_q.branch_taken <= 1'b1;
					end
					OP_BGT: if (gt_q) begin
						pc_q <= target; res_q.next_pc <= target; res_q.branch_taken <= 1'b1;
					end
					OP_B, OP_CALL: begin
						pc_q <= target; res_q.next_pc <= target; res_q.branch_taken <= 1'b1;
					end
					OP_RET: begin
						pc_q <= regs_q[15]; res_q.next_pc <= regs_q[15];
						res_q.branch_taken <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_item = res_q;

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && !halt_q && item_q.command == CMD_LOAD && ldp_q) |=> !ldp_q)
		else $error("pending load not cleared");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halt_q) |-> halt_q) else $error("halt dropped");
	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_q.mem_read && res_q.mem_write)) else $error("read and write together");
endmodule
`default_nettype wire

>>> tb/rieu_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module rieu_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_ready,
	input  rieu_pkg::in_item_t  in_data,
	input  wire                 out_valid,
	input  wire                 out_ready,
	input  rieu_pkg::out_item_t out_data,
	output int                  fail_count,
	output int                  results_owed
);
	import rieu_pkg::*;

	logic [31:0] regs [16];
	logic [31:0] pc;
	logic        gt_flag, eq_flag, ld_busy, halt_flag;
	logic [3:0]  ld_reg;
	out_item_t   owed_q [$];

	function automatic logic [31:0] second_operand(input logic [31:0] w);
		logic [31:0] v;
		if (!w[26])
			return regs[w[17:14]];
		v = {16'h0, w[15:0]};
		case (w[17:16])
			2'd0: v = {{16{w[15]}}, w[15:0]};
			2'd2: v = {w[15:0], 16'h0};
			default: ;
		endcase
		return v;
	endfunction

	task automatic execute_item(input in_item_t it);
		out_item_t   r;
		logic [31:0] w, a, b, res, target, ma, mb;
		logic [3:0]  rd;
		logic        wb, na, nb;
		r = '0;
		w = it.instruction;
		r.next_pc = pc;
		if (halt_flag) begin
		end else if (it.command == CMD_LOAD) begin
			if (ld_busy) begin
				regs[ld_reg] = it.load_data;
				r.reg_write = 1'b1;
				r.reg_index = ld_reg;
				r.reg_value = it.load_data;
				ld_busy = 1'b0;
			end
		end else if (ld_busy) begin
		end else if (w == HALT_WORD) begin
			halt_flag = 1'b1;
		end else begin
			rd = w[25:22];
			a = regs[w[21:18]];
			b = second_operand(w);
			target = pc + {{3{w[26]}}, w[26:0], 2'b00};
			r.next_pc = pc + 32'd4;
			res = '0;
			wb = 1'b1;
			case (w[31:27])
				OP_ADD: res = a + b;
				OP_SUB: res = a - b;
				OP_MUL: res = a * b;
				OP_DIV, OP_MOD: begin
					na = a[31];
					nb = b[31];
					ma = na ? -a : a;
					mb = nb ? -b : b;
					if (mb == 0) begin
						r.div_zero = 1'b1;
					end else if (w[31:27] == OP_DIV) begin
						res = ma / mb;
						if (na != nb)
							res = -res;
					end else begin
						res = ma % mb;
						if (na)
							res = -res;
					end
				end
				OP_CMP: begin
					gt_flag = $signed(a) > $signed(b);
					eq_flag = a == b;
					wb = 1'b0;
				end
				OP_AND: res = a & b;
				OP_OR:  res = a | b;
				OP_NOT: res = ~b;
				OP_MOV: res = b;
				OP_LSL: res = a << b[4:0];
				OP_LSR: res = a >> b[4:0];
				OP_ASR: res = $signed(a) >>> b[4:0];
				OP_LD: begin
					r.mem_read = 1'b1;
					r.mem_address = a + b;
					ld_busy = 1'b1;
					ld_reg = rd;
					wb = 1'b0;
				end
				OP_ST: begin
					r.mem_write = 1'b1;
					r.mem_address = a + b;
					r.store_data = regs[rd];
					wb = 1'b0;
				end
				OP_BEQ: begin
					if (eq_flag) begin
						r.next_pc = target;
						r.branch_taken = 1'b1;
					end
					wb = 1'b0;
				end
				OP_BGT: begin
					if (gt_flag) begin
						r.next_pc = target;
						r.branch_taken = 1'b1;
					end
					wb = 1'b0;
				end
				OP_B: begin
					r.next_pc = target;
					r.branch_taken = 1'b1;
					wb = 1'b0;
				end
				OP_CALL: begin
					res = pc + 32'd4;
					rd = 4'd15;
					r.next_pc = target;
					r.branch_taken = 1'b1;
				end
				OP_RET: begin
					r.next_pc = regs[15];
					r.branch_taken = 1'b1;
					wb = 1'b0;
				end
				default: wb = 1'b0;
			endcase
			if (wb) begin
				regs[rd] = res;
				r.reg_write = 1'b1;
				r.reg_index = rd;
				r.reg_value = res;
			end
		end
		pc = r.next_pc;
		r.halted = halt_flag;
		owed_q.push_back(r);
	endtask

	task automatic compare_result(input out_item_t got);
		out_item_t e;
		if (owed_q.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			fail_count++;
			return;
		end
		e = owed_q.pop_front();
		if (got.next_pc !== e.next_pc) begin
			$display("%0t: next_pc exp %h got %h", $time, e.next_pc, got.next_pc);
			fail_count++;
		end
		if (got.branch_taken !== e.branch_taken) begin
			$display("%0t: branch_taken exp %b got %b", $time, e.branch_taken,
				got.branch_taken);
			fail_count++;
		end
		if (got.mem_read !== e.mem_read) begin
			$display("%0t: mem_read exp %b got %b", $time, e.mem_read, got.mem_read);
			fail_count++;
		end
		if (got.mem_write !== e.mem_write) begin
			$display("%0t: mem_write exp %b got %b", $time, e.mem_write, got.mem_write);
			fail_count++;
		end
		if (got.mem_address !== e.mem_address) begin
			$display("%0t: mem_address exp %h got %h", $time, e.mem_address,
				got.mem_address);
			fail_count++;
		end
		if (got.store_data !== e.store_data) begin
			$display("%0t: store_data exp %h got %h", $time, e.store_data,
				got.store_data);
			fail_count++;
		end
		if (got.reg_write !== e.reg_write) begin
			$display("%0t: reg_write exp %b got %b", $time, e.reg_write, got.reg_write);
			fail_count++;
		end
		if (got.reg_index !== e.reg_index) begin
			$display("%0t: reg_index exp %h got %h", $time, e.reg_index, got.reg_index);
			fail_count++;
		end
		if (got.reg_value !== e.reg_value) begin
			$display("%0t: reg_value exp %h got %h", $time, e.reg_value, got.reg_value);
			fail_count++;
		end
		if (got.halted !== e.halted) begin
			$display("%0t: halted exp %b got %b", $time, e.halted, got.halted);
			fail_count++;
		end
		if (got.div_zero !== e.div_zero) begin
			$display("%0t: div_zero exp %b got %b", $time, e.div_zero, got.div_zero);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
	end

	assign results_owed = owed_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (regs[i])
				regs[i] = '0;
			regs[14] = STACK_TOP;
			pc = '0;
			gt_flag = 1'b0;
			eq_flag = 1'b0;
			ld_busy = 1'b0;
			ld_reg = '0;
			halt_flag = 1'b0;
			owed_q.delete();
		end else begin
			if (out_valid && out_ready)
				compare_result(out_data);
			if (in_valid && in_ready)
				execute_item(in_data);
		end
	end
endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import rieu_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	int        fail_count;
	int        results_owed;
	int        idle_cycles = 0;
	logic      calm = 1'b0;
	logic      in_load_mode = 1'b0;

	always #5 clk = ~clk;

	risc_instruction_execute_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	rieu_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.fail_count  (fail_count),
		.results_owed(results_owed)
	);

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 21);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] make_word(input logic [4:0] op);
		logic [31:0] w;
		w = $urandom;
		w[31:27] = op;
		if ($urandom_range(3) == 0)
			w[15:0] = ($urandom_range(1)) ? 16'h8000 : 16'h0000;
		// keep branch targets mostly near the current address
		if (op >= OP_BEQ && op <= OP_CALL && $urandom_range(3) != 0)
			w[26:0] = {{17{w[9]}}, w[9:0]};
		return w;
	endfunction

	task automatic send_item(input logic cmd, input logic [31:0] w,
		input logic [31:0] ld);
		if (!calm) begin
			while ($urandom_range(99) < 21) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= '{command: cmd, instruction: w, load_data: ld};
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic random_item();
		logic [4:0] op;
		logic [31:0] w;
		int sel;
		sel = $urandom_range(99);
		if (in_load_mode || sel < 6) begin
			send_item(CMD_LOAD, $urandom, $urandom);
			in_load_mode = 1'b0;
			return;
		end
		op = 5'($urandom_range(20));
		if (sel < 8)
			op = 5'($urandom_range(31, 21));
		w = make_word(op);
		if (op == OP_DIV || op == OP_MOD) begin
			if ($urandom_range(3) == 0)
				w[17:0] = {2'b00, 16'h0000};
		end
		if (op == OP_LD && $urandom_range(3) != 0)
			in_load_mode = 1'b1;
		send_item(CMD_EXEC, w, $urandom);
	endtask

	task automatic run_directed();
		for (int op = OP_ADD; op <= OP_RET; op++)
			send_item(CMD_EXEC, make_word(op[4:0]), '0);
		// divisor zero, most negative over minus one
		send_item(CMD_EXEC, {OP_MOV, 1'b1, 4'd1, 4'd0, 2'd2, 16'h8000}, '0);
		send_item(CMD_EXEC, {OP_DIV, 1'b1, 4'd2, 4'd1, 2'd0, 16'hffff}, '0);
		send_item(CMD_EXEC, {OP_MOD, 1'b1, 4'd3, 4'd1, 2'd0, 16'hffff}, '0);
		send_item(CMD_EXEC, {OP_DIV, 1'b1, 4'd3, 4'd1, 2'd1, 16'h0000}, '0);
		// load data without pending load, then stall during a load
		send_item(CMD_LOAD, '0, 32'hffffffff);
		send_item(CMD_EXEC, {OP_LD, 1'b1, 4'd5, 4'd14, 2'd3, 16'hffff}, '0);
		send_item(CMD_EXEC, {OP_ADD, 1'b0, 4'd6, 4'd5, 4'd5, 14'h0}, '0);
		send_item(CMD_LOAD, 32'hffffffff, 32'hffffffff);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int i = 0; i < 1200; i++) begin
			calm <= (i >= 500 && i < 650);
			random_item();
		end
		calm <= 1'b0;
		send_item(CMD_EXEC, HALT_WORD, '0);
		send_item(CMD_EXEC, {OP_ADD, 1'b1, 4'd1, 4'd1, 2'd0, 16'h0001}, '0);
		send_item(CMD_LOAD, '0, 32'h1234);
		in_valid <= 1'b0;
		while (results_owed != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
design/rieu_pkg.sv
design/rieu_ctrl.sv
design/rieu_datapath.sv
design/risc_instruction_execute_unit.sv
tb/rieu_checker.sv
tb/tb.sv
